// ----- rtl/lpd_pkg.sv -----
package lpd_pkg;

	localparam int unsigned MAX_MESSAGE_DEF = 65536;
	localparam int unsigned MIN_LENGTH      = 2;
	localparam int unsigned MAX_LEN_W       = 17;
	localparam int unsigned BYTE_W          = 8;
	localparam int unsigned LEN_W           = 32;
	localparam int unsigned APB_AW          = 3;

	localparam logic [1:0] LAST_PREFIX_BYTE = 2'd3;

	localparam logic REG_LENGTH_BIG_ENDIAN = 1'b0;
	localparam logic REG_MAX_LENGTH        = 1'b1;

	localparam logic [MAX_LEN_W-1:0] MAX_LENGTH_RST = 17'h10000;

endpackage

// ----- rtl/length_prefixed_deframer.sv -----
// Splits a byte stream framed as a 32-bit length prefix followed by that many payload
// bytes. Each prefix byte is absorbed without output; payload bytes leave on the master
// side one per transfer, with tlast on the final byte. A prefix whose length is below two
// or above min(max_length, MAX_MESSAGE) yields one transfer with tuser set and zero data,
// and the next byte starts a new prefix. One byte is taken per clock cycle while m_tready
// is high; a result held by a low m_tready stalls s_tready until it is taken, so throughput
// is one byte per cycle, and m_tdata is registered from s_tdata. length_big_endian is
// sampled on the fourth prefix byte; register writes affect prefixes completed after them.
module length_prefixed_deframer
	import lpd_pkg::*;
#(
	parameter int unsigned MAX_MESSAGE = MAX_MESSAGE_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,  // [7:0] data_byte
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,  // [7:0] payload_byte
	output logic              m_tlast,
	output logic              m_tuser   // [0] length_error
);

	localparam int unsigned RW = $clog2(MAX_MESSAGE + 1);
	localparam logic [LEN_W-1:0] MAX_MSG_L = LEN_W'(MAX_MESSAGE);
	localparam logic [LEN_W-1:0] MIN_LEN_L = LEN_W'(MIN_LENGTH);

	logic                 big_endian_q;
	logic [MAX_LEN_W-1:0] max_length_q;
	logic                 in_payload_q;
	logic [1:0]           prefix_cnt_q;
	logic [23:0]          acc_q;
	logic [RW-1:0]        rem_q;
	logic                 out_valid_q;
	logic [BYTE_W-1:0]    out_data_q;
	logic                 out_last_q;
	logic                 out_err_q;

	logic                 cfg_wr;
	logic                 reg_idx;
	logic                 s_xfer;
	logic [LEN_W-1:0]     raw_len;
	logic [LEN_W-1:0]     len;
	logic [LEN_W-1:0]     max_ext;
	logic [LEN_W-1:0]     limit;
	logic                 prefix_done;
	logic                 len_bad;
	logic [RW-1:0]        rem_dec;
	logic                 emit;

	assign pready  = 1'b1;
	assign reg_idx = paddr[2];
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_comb begin
		case (reg_idx)
			REG_LENGTH_BIG_ENDIAN: prdata = {31'b0, big_endian_q};
			REG_MAX_LENGTH:        prdata = {{(32 - MAX_LEN_W){1'b0}}, max_length_q};
			default:               prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			big_endian_q <= 1'b1;
			max_length_q <= MAX_LENGTH_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_LENGTH_BIG_ENDIAN: big_endian_q <= pwdata[0];
				REG_MAX_LENGTH:        max_length_q <= pwdata[MAX_LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign s_tready = ~out_valid_q | m_tready;
	assign s_xfer   = s_tvalid & s_tready;

	assign raw_len = {acc_q, s_tdata};
	assign len     = big_endian_q ? raw_len
	                              : {raw_len[7:0], raw_len[15:8], raw_len[23:16], raw_len[31:24]};
	assign max_ext = LEN_W'(max_length_q);
	assign limit   = (max_ext < MAX_MSG_L) ? max_ext : MAX_MSG_L;
	assign len_bad = (len < MIN_LEN_L) | (len > limit);

	assign prefix_done = ~in_payload_q & (prefix_cnt_q == LAST_PREFIX_BYTE);
	assign rem_dec     = rem_q - RW'(1);
	assign emit        = in_payload_q | (prefix_done & len_bad);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_payload_q <= 1'b0;
			prefix_cnt_q <= '0;
			acc_q        <= '0;
			rem_q        <= '0;
		end else if (s_xfer) begin
			if (in_payload_q) begin
				rem_q <= rem_dec;
				if (rem_dec == '0) begin
					in_payload_q <= 1'b0;
				end
			end else begin
				acc_q        <= {acc_q[15:0], s_tdata};
				prefix_cnt_q <= prefix_cnt_q + 2'd1;
				if (prefix_done && !len_bad) begin
					rem_q        <= len[RW-1:0];
					in_payload_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_tready) begin
			out_valid_q <= s_xfer & emit;
		end
	end

	always_ff @(posedge clk) begin
		if (s_xfer && emit) begin
			out_data_q <= in_payload_q ? s_tdata : '0;
			out_last_q <= in_payload_q & (rem_dec == '0);
			out_err_q  <= ~in_payload_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_err_q;

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0 && !m_tlast)
		else $error("error transfer carries data or tlast");

	a_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		in_payload_q |-> rem_q != '0)
		else $error("payload phase with no bytes remaining");

	a_rem_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!in_payload_q |-> rem_q == '0)
		else $error("byte count left over in length phase");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		s_xfer && in_payload_q && rem_q == RW'(1) |=> !in_payload_q && m_tvalid && m_tlast)
		else $error("final payload byte did not end the frame");

endmodule

// ----- bench/tb_length_prefixed_deframer.sv -----
`timescale 1ns / 1ps

module tb_length_prefixed_deframer;
	import lpd_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       err;
	} beat_t;

	localparam logic [APB_AW-1:0] ADDR_BIG_ENDIAN = APB_AW'(4 * int'(REG_LENGTH_BIG_ENDIAN));
	localparam logic [APB_AW-1:0] ADDR_MAX_LENGTH = APB_AW'(4 * int'(REG_MAX_LENGTH));

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              psel     = 1'b0;
	logic              penable  = 1'b0;
	logic              pwrite   = 1'b0;
	logic [APB_AW-1:0] paddr    = '0;
	logic [31:0]       pwdata   = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [7:0]        s_tdata  = '0;  // [7:0] data_byte
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [7:0]        m_tdata;        // [7:0] payload_byte
	logic              m_tlast;
	logic              m_tuser;        // [0] length_error

	// deframer shadow state
	logic                 cfg_big_endian = 1'b1;
	logic [MAX_LEN_W-1:0] cfg_max_len    = MAX_LENGTH_RST;
	logic                 in_payload     = 1'b0;
	logic [1:0]           prefix_cnt     = '0;
	logic [LEN_W-1:0]     len_acc        = '0;
	logic [MAX_LEN_W-1:0] remaining      = '0;

	logic [7:0] byte_q[$];
	beat_t      payload_q[$];
	beat_t      got_beat;
	beat_t      want_beat;

	int  err_cnt      = 0;
	int  results_seen = 0;
	int  pushed_bytes = 0;
	int  gap_left     = 0;
	int  stall_left   = 0;
	int  hold_left    = 0;
	int  drv_burst    = 0;
	int  mon_burst    = 0;
	bit  fast_mode    = 1'b0;

	length_prefixed_deframer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#40ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic int eff_limit();
		return (cfg_max_len < MAX_MESSAGE_DEF) ? int'(cfg_max_len) : int'(MAX_MESSAGE_DEF);
	endfunction

	function automatic void deframe_byte(input logic [7:0] b);
		logic [LEN_W-1:0] len;
		if (in_payload) begin
			remaining = remaining - 1'b1;
			payload_q.push_back('{b, remaining == 0, 1'b0});
			if (remaining == 0)
				in_payload = 1'b0;
		end else begin
			len_acc = {len_acc[23:0], b};
			if (prefix_cnt != LAST_PREFIX_BYTE) begin
				prefix_cnt = prefix_cnt + 1'b1;
			end else begin
				len = cfg_big_endian ? len_acc
					: {len_acc[7:0], len_acc[15:8], len_acc[23:16], len_acc[31:24]};
				prefix_cnt = '0;
				len_acc    = '0;
				if (len < MIN_LENGTH || len > eff_limit()) begin
					payload_q.push_back('{8'h00, 1'b0, 1'b1});
				end else begin
					remaining  = len[MAX_LEN_W-1:0];
					in_payload = 1'b1;
				end
			end
		end
	endfunction

	function automatic int draw_wait(inout int burst);
		if (fast_mode)
			return 0;
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			burst = $urandom_range(20, 60);
			return 0;
		end
		return $urandom_range(0, 4);
	endfunction

	function automatic void flag_beat(input string what, input beat_t want, input beat_t got);
		err_cnt++;
		if (err_cnt <= 10)
			$display("%0t %s: expected data=%02h last=%0b err=%0b, got data=%02h last=%0b err=%0b",
				$realtime, what, want.data, want.last, want.err, got.data, got.last, got.err);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			gap_left = 0;
		end else begin
			if (s_tvalid && s_tready)
				deframe_byte(s_tdata);
			if (s_tvalid && !s_tready) begin
				s_tvalid <= 1'b1;  // hold until taken
			end else if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (byte_q.size() != 0) begin
				s_tvalid <= 1'b1;
				s_tdata  <= byte_q.pop_front();
				gap_left = draw_wait(drv_burst);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
			hold_left  = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_beat = '{m_tdata, m_tlast, m_tuser};
				if (payload_q.size() == 0) begin
					flag_beat("unexpected transfer", '0, got_beat);
				end else begin
					want_beat = payload_q.pop_front();
					if (got_beat !== want_beat)
						flag_beat("transfer mismatch", want_beat, got_beat);
				end
				results_seen++;
				stall_left = draw_wait(mon_burst);
				// back-pressure long enough to fill the block and stall its input
				if (results_seen % 700 == 350)
					hold_left = 250;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic push_byte(input logic [7:0] b);
		byte_q.push_back(b);
		pushed_bytes++;
	endtask

	task automatic push_payload(input int n);
		repeat (n) push_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic push_prefix(input logic [LEN_W-1:0] len);
		if (cfg_big_endian) begin
			push_byte(len[31:24]);
			push_byte(len[23:16]);
			push_byte(len[15:8]);
			push_byte(len[7:0]);
		end else begin
			push_byte(len[7:0]);
			push_byte(len[15:8]);
			push_byte(len[23:16]);
			push_byte(len[31:24]);
		end
	endtask

	task automatic push_frame(input logic [LEN_W-1:0] len);
		push_prefix(len);
		if (len >= MIN_LENGTH && len <= eff_limit())
			push_payload(int'(len));
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (byte_q.size() != 0 || s_tvalid || payload_q.size() != 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic reg_write(input logic [APB_AW-1:0] addr, input logic [31:0] data);
		logic [31:0] want;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (addr == ADDR_BIG_ENDIAN)
			cfg_big_endian = data[0];
		else
			cfg_max_len = data[MAX_LEN_W-1:0];
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		psel <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		want = (addr == ADDR_BIG_ENDIAN) ? 32'(cfg_big_endian) : 32'(cfg_max_len);
		if (prdata !== want) begin
			err_cnt++;
			if (err_cnt <= 10)
				$display("%0t register readback at %0h: expected %08h, got %08h",
					$realtime, addr, want, prdata);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_config(input logic be, input logic [31:0] max_word);
		reg_write(ADDR_BIG_ENDIAN, 32'(be));
		reg_write(ADDR_MAX_LENGTH, max_word);
	endtask

	task automatic random_stage(input logic be, input logic [31:0] max_word);
		int lim;
		int pick;
		int start;
		logic [LEN_W-1:0] len;
		set_config(be, max_word);
		lim   = eff_limit();
		start = pushed_bytes;
		while (pushed_bytes - start < 260) begin
			pick = $urandom_range(0, 99);
			if (pick < 70)
				len = $urandom_range(MIN_LENGTH, (lim < 48) ? lim : 48);
			else if (pick < 80)
				len = (lim <= 300) ? lim : $urandom_range(200, 300);
			else if (pick < 88)
				len = lim + 1;
			else if (pick < 94)
				len = $urandom_range(0, 1);
			else
				len = $urandom();
			push_frame(len);
		end
		wait_drained();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_prefix(2);
		push_byte(8'h00);
		push_byte(8'hFF);
		push_prefix(0);
		wait_drained();

		// switch byte order between the second and third prefix byte
		push_byte(8'h03);
		push_byte(8'h00);
		wait_drained();
		reg_write(ADDR_BIG_ENDIAN, 32'hFFFF_FFFE);
		push_byte(8'h00);
		push_byte(8'h00);
		push_payload(3);
		wait_drained();

		// lower the limit while a payload is under way
		push_prefix(4);
		push_payload(2);
		wait_drained();
		reg_write(ADDR_MAX_LENGTH, 32'h0000_0002);
		push_payload(2);
		push_frame(3);
		wait_drained();

		set_config(1'b1, MAX_MESSAGE_DEF);
		fast_mode <= 1'b1;
		push_frame(MAX_MESSAGE_DEF + 1);
		wait_drained();
		fast_mode <= 1'b0;

		random_stage(1'b1, 32'd65536);
		random_stage(1'b0, 32'hFFFE_0064);
		random_stage(1'b1, 32'd2);
		random_stage(1'b0, 32'h0001_FFFF);
		random_stage(1'b1, 32'd0);
		random_stage(1'b0, 32'd1);
		random_stage(1'b1, 32'd37);

		repeat (10) @(posedge clk);
		if (payload_q.size() != 0) begin
			err_cnt += payload_q.size();
			$display("%0t %0d expected transfers never arrived", $realtime, payload_q.size());
		end
		if (err_cnt == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/lpd_pkg.sv
rtl/length_prefixed_deframer.sv
bench/tb_length_prefixed_deframer.sv
